// ----- rtl/tep_pkg.sv -----
package tep_pkg;

	// Default depth of the escape sequence buffer.
	localparam int ESC_BUF_LEN_DEF = 16;

	// Control codes seen on the byte stream.
	localparam logic [7:0] CODE_ESC = 8'h1B;
	localparam logic [7:0] CODE_SI  = 8'h0F;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_SEMI = 8'h3B;
	localparam logic [7:0] CODE_ZERO = 8'h30;
	localparam logic [7:0] CODE_SPACE = 8'h20;

	// Intensity bits of the color attribute.
	localparam logic [7:0] FG_INTENS = 8'h08;
	localparam logic [7:0] BG_INTENS = 8'h80;

	// Reset values.
	localparam logic [7:0] WIDTH_RST     = 8'd80;
	localparam logic [7:0] HEIGHT_RST    = 8'd50;
	localparam logic [7:0] BASE_FORE_RST = 8'd2;
	localparam logic [7:0] BASE_BACK_RST = 8'd32;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Result command codes.
	localparam logic [3:0] CMD_CHAR      = 4'd0;
	localparam logic [3:0] CMD_MOVE      = 4'd1;
	localparam logic [3:0] CMD_ERASE_EOL = 4'd2;
	localparam logic [3:0] CMD_ERASE_EOS = 4'd3;
	localparam logic [3:0] CMD_ERASE_CH  = 4'd4;
	localparam logic [3:0] CMD_INS_CH    = 4'd5;
	localparam logic [3:0] CMD_DEL_CH    = 4'd6;
	localparam logic [3:0] CMD_INS_LN    = 4'd7;
	localparam logic [3:0] CMD_DEL_LN    = 4'd8;
	localparam logic [3:0] CMD_SCROLL_DN = 4'd9;
	localparam logic [3:0] CMD_SCROLL_UP = 4'd10;
	localparam logic [3:0] CMD_SET_ATTR  = 4'd11;

	// Actions the datapath applies when it loads a result.
	typedef enum logic [4:0] {
		OP_CHAR, OP_CR, OP_LF, OP_UP, OP_DOWN, OP_RIGHT, OP_LEFT, OP_HOME,
		OP_ERASE_EOL, OP_ERASE_EOS, OP_YPOS, OP_ERASE_CH, OP_INS_CH, OP_DEL_CH,
		OP_INS_LN, OP_DEL_LN, OP_GOTO, OP_SCROLL_DN, OP_SCROLL_UP, OP_VIDEO,
		OP_INTENS
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_FETCH, ST_SCAN, ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic emit;
		op_t  op;
		logic buf_write;
		logic first_is_cur;
		logic scan_clear;
		logic scan_step;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
		logic scan_stop;
	} dp_status_t;

	// Upper quarter of the code-page table.
	localparam logic [7:0] XLAT_HI [64] = '{
		8'hEE, 8'hA0, 8'hA1, 8'hE6, 8'hA4, 8'hA5, 8'hE4, 8'hA3,
		8'hE5, 8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
		8'hAF, 8'hEF, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hA6, 8'hA2,
		8'hEC, 8'hEB, 8'hA7, 8'hE8, 8'hED, 8'hE9, 8'hE7, 8'hEA,
		8'h9E, 8'h80, 8'h81, 8'h96, 8'h84, 8'h85, 8'h94, 8'h83,
		8'h95, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E,
		8'h8F, 8'h9F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h86, 8'h82,
		8'h9C, 8'h9B, 8'h87, 8'h98, 8'h9D, 8'h99, 8'h97, 8'h9A
	};

	// Code-page translation of a plain character.
	function automatic logic [7:0] xlat_byte(input logic [7:0] b);
		logic [7:0] r;
		if (b[7:6] == 2'b11) begin
			r = XLAT_HI[b[5:0]];
		end else if (b[7:4] == 4'h8) begin
			r = {4'hD, b[3:0]};
		end else if (b[7:4] == 4'hA) begin
			r = {4'hC, b[3:0]};
		end else begin
			r = b;
		end
		return r;
	endfunction

	function automatic logic [3:0] op_to_cmd(input op_t op);
		logic [3:0] c;
		case (op)
			OP_CHAR, OP_CR, OP_LF: c = CMD_CHAR;
			OP_ERASE_EOL:          c = CMD_ERASE_EOL;
			OP_ERASE_EOS:          c = CMD_ERASE_EOS;
			OP_ERASE_CH:           c = CMD_ERASE_CH;
			OP_INS_CH:             c = CMD_INS_CH;
			OP_DEL_CH:             c = CMD_DEL_CH;
			OP_INS_LN:             c = CMD_INS_LN;
			OP_DEL_LN:             c = CMD_DEL_LN;
			OP_SCROLL_DN:          c = CMD_SCROLL_DN;
			OP_SCROLL_UP:          c = CMD_SCROLL_UP;
			OP_VIDEO, OP_INTENS:   c = CMD_SET_ATTR;
			default:               c = CMD_MOVE;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] step_up(input logic [7:0] v, input logic [7:0] lim);
		return (v < lim) ? v + 8'd1 : lim;
	endfunction

	function automatic logic [7:0] step_down(input logic [7:0] v);
		return (v != 8'd0) ? v - 8'd1 : 8'd0;
	endfunction

	// Argument (already at least one) minus one, limited to the last line or column.
	function automatic logic [7:0] arg_pos(input logic [15:0] n, input logic [7:0] lim);
		logic [15:0] m;
		m = n - 16'd1;
		return (m > {8'd0, lim}) ? lim : m[7:0];
	endfunction

endpackage

// ----- rtl/terminal_escape_parser_top.sv -----
// Terminal escape parser.
// Input channel (in_valid/in_ready, byte_in) takes one terminal output byte per
// transfer. Output channel (out_valid/out_ready) carries one command per completed
// action: command code, count, cursor after the action, translated character and
// the live attribute. Bytes that only extend an escape sequence give no result.
// The configuration port (cfg_write, cfg_index, cfg_data) sets screen width and
// height, one write per cycle; it must be used only while the block is idle, which
// the block does not enforce. A plain byte or a sequence not ending in X, @, P, L,
// M, H, T or S shows its result in the cycle after the transfer. Other bracket
// sequences walk their argument bytes in the escape buffer one byte per cycle
// through its single read port, then wait for a free output. A new byte is taken
// once the previous one is done: one byte per cycle for plain text unless stalled.
// A stalled result holds the output register and the input is not taken until it
// is transferred. Reset clears the cursor to the top left, the colors to green,
// and drops any open sequence; the screen size returns to 80 by 50.
module terminal_escape_parser_top #(
	parameter int ESC_BUF_LEN = tep_pkg::ESC_BUF_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  command,
	output logic [15:0] count,
	output logic [7:0]  cursor_column,
	output logic [7:0]  cursor_line,
	output logic [7:0]  char_code,
	output logic [7:0]  attribute
);

	localparam int AW = $clog2(ESC_BUF_LEN);

	tep_pkg::ctrl_cmd_t  cmd;
	tep_pkg::dp_status_t st;
	logic [AW-1:0]       waddr, raddr;

	tep_ctrl #(.BUF_LEN(ESC_BUF_LEN)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.byte_in  (byte_in),
		.st       (st),
		.cmd      (cmd),
		.waddr    (waddr),
		.raddr    (raddr)
	);

	tep_dp #(.BUF_LEN(ESC_BUF_LEN)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.byte_in       (byte_in),
		.cmd           (cmd),
		.waddr         (waddr),
		.raddr         (raddr),
		.st            (st),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.command       (command),
		.count         (count),
		.cursor_column (cursor_column),
		.cursor_line   (cursor_line),
		.char_code     (char_code),
		.attribute     (attribute)
	);

endmodule

// ----- rtl/tep_ctrl.sv -----
module tep_ctrl #(
	parameter int BUF_LEN = tep_pkg::ESC_BUF_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 byte_in,
	input  tep_pkg::dp_status_t        st,
	output tep_pkg::ctrl_cmd_t         cmd,
	output logic [$clog2(BUF_LEN)-1:0] waddr,
	output logic [$clog2(BUF_LEN)-1:0] raddr
);

	localparam int AW = $clog2(BUF_LEN);
	localparam logic [AW-1:0] LEN_FULL = AW'(BUF_LEN - 1);
	localparam logic [AW-1:0] ONE = AW'(1);
	localparam logic [AW-1:0] TWO = AW'(2);

	tep_pkg::state_t state_q, state_n;
	tep_pkg::op_t    op_q, op_n;
	logic            active_q, active_n;
	logic            prefix_y_q, prefix_y_n;
	logic [AW-1:0]   len_q, len_n;
	logic [AW-1:0]   pos_q, pos_n;
	logic            acc;
	logic            is_digit;

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tep_pkg::ST_IDLE;
			op_q       <= tep_pkg::OP_CHAR;
			active_q   <= 1'b0;
			prefix_y_q <= 1'b0;
			len_q      <= '0;
			pos_q      <= '0;
		end else begin
			state_q    <= state_n;
			op_q       <= op_n;
			active_q   <= active_n;
			prefix_y_q <= prefix_y_n;
			len_q      <= len_n;
			pos_q      <= pos_n;
		end
	end

	assign acc      = in_valid && in_ready;
	assign is_digit = byte_in inside {[8'h30:8'h39]};
	assign waddr    = len_q;
	assign raddr    = pos_q;

	// Byte decode and sequencing of the argument scan.
	always_comb begin
		state_n    = state_q;
		op_n       = op_q;
		active_n   = active_q;
		prefix_y_n = prefix_y_q;
		len_n      = len_q;
		pos_n      = pos_q;
		in_ready   = (state_q == tep_pkg::ST_IDLE) && !st.out_busy;
		cmd.emit         = 1'b0;
		cmd.op           = op_q;
		cmd.buf_write    = 1'b0;
		cmd.first_is_cur = 1'b0;
		cmd.scan_clear   = 1'b0;
		cmd.scan_step    = 1'b0;
		case (state_q)
			tep_pkg::ST_IDLE: begin
				if (acc && byte_in != tep_pkg::CODE_SI) begin
					if (byte_in == tep_pkg::CODE_ESC) begin
						active_n = 1'b1;
						len_n    = '0;
					end else if (!active_q) begin
						cmd.emit = 1'b1;
						if (byte_in == tep_pkg::CODE_CR) cmd.op = tep_pkg::OP_CR;
						else if (byte_in == tep_pkg::CODE_LF) cmd.op = tep_pkg::OP_LF;
						else cmd.op = tep_pkg::OP_CHAR;
					end else if (len_q == '0) begin
						// First byte after ESC: a VT52 form or a sequence prefix.
						active_n = 1'b0;
						cmd.emit = 1'b1;
						case (byte_in)
							"A": cmd.op = tep_pkg::OP_UP;
							"B": cmd.op = tep_pkg::OP_DOWN;
							"C": cmd.op = tep_pkg::OP_RIGHT;
							"D": cmd.op = tep_pkg::OP_LEFT;
							"H": cmd.op = tep_pkg::OP_HOME;
							"K": cmd.op = tep_pkg::OP_ERASE_EOL;
							"J": cmd.op = tep_pkg::OP_ERASE_EOS;
							"Y", "[": begin
								cmd.emit   = 1'b0;
								active_n   = 1'b1;
								prefix_y_n = (byte_in == "Y");
								len_n      = ONE;
							end
							default: cmd.emit = 1'b0;
						endcase
					end else if (len_q >= LEN_FULL) begin
						active_n = 1'b0;
					end else begin
						cmd.buf_write = 1'b1;
						len_n         = len_q + ONE;
						active_n      = 1'b0;
						if (prefix_y_q) begin
							if (len_q == TWO) begin
								cmd.emit = 1'b1;
								cmd.op   = tep_pkg::OP_YPOS;
							end else begin
								active_n = 1'b1;
							end
						end else begin
							cmd.first_is_cur = (len_q == ONE);
							case (byte_in)
								"A": begin cmd.emit = 1'b1; cmd.op = tep_pkg::OP_UP; end
								"B": begin cmd.emit = 1'b1; cmd.op = tep_pkg::OP_DOWN; end
								"C": begin cmd.emit = 1'b1; cmd.op = tep_pkg::OP_RIGHT; end
								"D": begin cmd.emit = 1'b1; cmd.op = tep_pkg::OP_LEFT; end
								"K": begin cmd.emit = 1'b1; cmd.op = tep_pkg::OP_ERASE_EOL; end
								"r": begin cmd.emit = 1'b1; cmd.op = tep_pkg::OP_VIDEO; end
								"u": begin cmd.emit = 1'b1; cmd.op = tep_pkg::OP_INTENS; end
								"X", "@", "P", "L", "M", "H", "T", "S": begin
									// Arguments are walked from the buffer before the result.
									case (byte_in)
										"X":     op_n = tep_pkg::OP_ERASE_CH;
										"@":     op_n = tep_pkg::OP_INS_CH;
										"P":     op_n = tep_pkg::OP_DEL_CH;
										"L":     op_n = tep_pkg::OP_INS_LN;
										"M":     op_n = tep_pkg::OP_DEL_LN;
										"H":     op_n = tep_pkg::OP_GOTO;
										"T":     op_n = tep_pkg::OP_SCROLL_DN;
										default: op_n = tep_pkg::OP_SCROLL_UP;
									endcase
									cmd.scan_clear = 1'b1;
									pos_n          = ONE;
									state_n = (len_q >= TWO) ? tep_pkg::ST_FETCH : tep_pkg::ST_EMIT;
								end
								default: active_n = is_digit || (byte_in == tep_pkg::CODE_SEMI);
							endcase
						end
					end
				end
			end
			tep_pkg::ST_FETCH: begin
				pos_n   = pos_q + ONE;
				state_n = tep_pkg::ST_SCAN;
			end
			tep_pkg::ST_SCAN: begin
				// The read data holds the entry one below the pointer.
				cmd.scan_step = 1'b1;
				if (st.scan_stop || pos_q == len_q - ONE) begin
					state_n = tep_pkg::ST_EMIT;
				end else begin
					pos_n = pos_q + ONE;
				end
			end
			tep_pkg::ST_EMIT: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_n  = tep_pkg::ST_IDLE;
				end
			end
			default: state_n = tep_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/tep_dp.sv -----
module tep_dp #(
	parameter int BUF_LEN = tep_pkg::ESC_BUF_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [7:0]                 cfg_data,
	input  logic [7:0]                 byte_in,
	input  tep_pkg::ctrl_cmd_t         cmd,
	input  logic [$clog2(BUF_LEN)-1:0] waddr,
	input  logic [$clog2(BUF_LEN)-1:0] raddr,
	output tep_pkg::dp_status_t        st,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [3:0]                 command,
	output logic [15:0]                count,
	output logic [7:0]                 cursor_column,
	output logic [7:0]                 cursor_line,
	output logic [7:0]                 char_code,
	output logic [7:0]                 attribute
);

	localparam int AW = $clog2(BUF_LEN);

	logic [7:0]  buf_mem [BUF_LEN];
	logic [7:0]  rd_q;
	logic [7:0]  first_q;
	logic [7:0]  width_q, height_q;
	logic [7:0]  col_q, row_q, bf_q, bb_q, lf_q, lb_q;
	logic [7:0]  col_n, row_n, bf_n, bb_n, lf_n, lb_n;
	logic [15:0] n0_q, n1_q;
	logic        phase_q;
	logic        ov_q;
	logic [3:0]  cmd_q;
	logic [15:0] cnt_q, cnt_n;
	logic [7:0]  chr_q, chr_n;
	logic [7:0]  last_col, last_row, first_sel, y_row, y_col;
	logic [15:0] n0_eff, n1_eff, nsel;
	logic [19:0] acc_val;
	logic [15:0] acc_sat;
	logic        rd_digit, rd_semi;

	// Escape buffer, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.buf_write) buf_mem[waddr] <= byte_in;
		if (cmd.buf_write && waddr == AW'(1)) first_q <= byte_in;
		rd_q <= buf_mem[raddr];
	end

	// Decimal scan: one buffered byte per cycle.
	assign rd_digit = rd_q inside {[8'h30:8'h39]};
	assign rd_semi  = (rd_q == tep_pkg::CODE_SEMI);
	assign nsel     = phase_q ? n1_q : n0_q;
	assign acc_val  = ({4'd0, nsel} << 3) + ({4'd0, nsel} << 1) + {12'd0, rd_q - tep_pkg::CODE_ZERO};
	assign acc_sat  = (acc_val > 20'd65535) ? 16'hFFFF : acc_val[15:0];
	assign st.scan_stop = !rd_digit && !(rd_semi && !phase_q);
	assign st.out_busy  = ov_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n0_q    <= '0;
			n1_q    <= '0;
			phase_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			n0_q    <= '0;
			n1_q    <= '0;
			phase_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (rd_digit) begin
				if (phase_q) n1_q <= acc_sat;
				else n0_q <= acc_sat;
			end else if (rd_semi && !phase_q) begin
				phase_q <= 1'b1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tep_pkg::WIDTH_RST;
			height_q <= tep_pkg::HEIGHT_RST;
		end else if (cfg_write) begin
			if (cfg_index == tep_pkg::REG_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data;
		end
	end

	assign last_col  = (width_q == 8'd0) ? 8'd0 : width_q - 8'd1;
	assign last_row  = (height_q == 8'd0) ? 8'd0 : height_q - 8'd1;
	assign n0_eff    = (n0_q == 16'd0) ? 16'd1 : n0_q;
	assign n1_eff    = (n1_q == 16'd0) ? 16'd1 : n1_q;
	assign first_sel = cmd.first_is_cur ? byte_in : first_q;
	assign y_row = (first_q >= tep_pkg::CODE_SPACE) ? first_q - tep_pkg::CODE_SPACE : 8'd0;
	assign y_col = (byte_in >= tep_pkg::CODE_SPACE) ? byte_in - tep_pkg::CODE_SPACE : 8'd0;

	// Effect of the action on cursor and attributes.
	always_comb begin
		col_n = col_q;
		row_n = row_q;
		bf_n  = bf_q;
		bb_n  = bb_q;
		lf_n  = lf_q;
		lb_n  = lb_q;
		cnt_n = 16'd1;
		chr_n = 8'd0;
		case (cmd.op)
			tep_pkg::OP_CHAR: begin
				col_n = tep_pkg::step_up(col_q, last_col);
				chr_n = tep_pkg::xlat_byte(byte_in);
			end
			tep_pkg::OP_CR: begin
				col_n = 8'd0;
				chr_n = tep_pkg::xlat_byte(byte_in);
			end
			tep_pkg::OP_LF: begin
				row_n = tep_pkg::step_up(row_q, last_row);
				chr_n = tep_pkg::xlat_byte(byte_in);
			end
			tep_pkg::OP_UP:    row_n = tep_pkg::step_down(row_q);
			tep_pkg::OP_DOWN:  row_n = tep_pkg::step_up(row_q, last_row);
			tep_pkg::OP_RIGHT: col_n = tep_pkg::step_up(col_q, last_col);
			tep_pkg::OP_LEFT:  col_n = tep_pkg::step_down(col_q);
			tep_pkg::OP_HOME: begin
				col_n = 8'd0;
				row_n = 8'd0;
			end
			tep_pkg::OP_YPOS: begin
				row_n = (y_row > last_row) ? last_row : y_row;
				col_n = (y_col > last_col) ? last_col : y_col;
			end
			tep_pkg::OP_ERASE_CH, tep_pkg::OP_INS_CH, tep_pkg::OP_DEL_CH,
			tep_pkg::OP_INS_LN, tep_pkg::OP_DEL_LN: cnt_n = n0_eff;
			tep_pkg::OP_GOTO: begin
				row_n = tep_pkg::arg_pos(n0_eff, last_row);
				col_n = tep_pkg::arg_pos(n1_eff, last_col);
			end
			tep_pkg::OP_SCROLL_DN: begin
				cnt_n = n0_eff;
				col_n = 8'd0;
				row_n = 8'd0;
			end
			tep_pkg::OP_SCROLL_UP: begin
				cnt_n = n0_eff;
				col_n = 8'd0;
				row_n = last_row;
			end
			tep_pkg::OP_VIDEO: begin
				if (first_sel == tep_pkg::CODE_ZERO) begin
					lf_n = bf_q;
					lb_n = 8'd0;
				end else begin
					lf_n = 8'd0;
					lb_n = bb_q;
				end
			end
			tep_pkg::OP_INTENS: begin
				if (first_sel == tep_pkg::CODE_ZERO) begin
					bf_n = bf_q & ~tep_pkg::FG_INTENS;
					bb_n = bb_q & ~tep_pkg::BG_INTENS;
				end else begin
					bf_n = (bf_q != 8'd0) ? (bf_q | tep_pkg::FG_INTENS) : bf_q;
					bb_n = (bb_q != 8'd0) ? (bb_q | tep_pkg::BG_INTENS) : bb_q;
				end
				if (lf_q != 8'd0) lf_n = bf_n;
				if (lb_q != 8'd0) lb_n = bb_n;
			end
			default: ;
		endcase
	end

	// Cursor, attribute and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 8'd0;
			row_q <= 8'd0;
			bf_q  <= tep_pkg::BASE_FORE_RST;
			bb_q  <= tep_pkg::BASE_BACK_RST;
			lf_q  <= tep_pkg::BASE_FORE_RST;
			lb_q  <= tep_pkg::BASE_BACK_RST;
			ov_q  <= 1'b0;
		end else if (cmd.emit) begin
			col_q <= col_n;
			row_q <= row_n;
			bf_q  <= bf_n;
			bb_q  <= bb_n;
			lf_q  <= lf_n;
			lb_q  <= lb_n;
			ov_q  <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cmd_q <= tep_pkg::op_to_cmd(cmd.op);
			cnt_q <= cnt_n;
			chr_q <= chr_n;
		end
	end

	// Cursor and attribute change only when a result is loaded into a free slot.
	assign out_valid     = ov_q;
	assign command       = cmd_q;
	assign count         = cnt_q;
	assign char_code     = chr_q;
	assign cursor_column = col_q;
	assign cursor_line   = row_q;
	assign attribute     = lb_q | lf_q;

endmodule

// ----- rtl/tep_checker.sv -----
module tep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  command,
	input logic [15:0] count,
	input logic [7:0]  char_code
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) && $stable(count))
		else $error("result changed while stalled");

	// No byte is taken while a result is stalled.
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// Only character commands carry a code.
	a_char_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command != tep_pkg::CMD_CHAR |-> char_code == 8'd0)
		else $error("char code on non-character command");

	// Commands without an argument report a count of one.
	a_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command == tep_pkg::CMD_CHAR || command == tep_pkg::CMD_MOVE ||
		command == tep_pkg::CMD_ERASE_EOL || command == tep_pkg::CMD_ERASE_EOS ||
		command == tep_pkg::CMD_SET_ATTR) |-> count == 16'd1)
		else $error("count not one");

endmodule

bind terminal_escape_parser_top tep_checker u_chk (.*);

// ----- tb/escape_checker.sv -----
// Watches both channels of the terminal escape parser, predicts each command
// from the accepted byte stream and compares it with what the block sends.
module escape_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  command,
	input  logic [15:0] count,
	input  logic [7:0]  cursor_column,
	input  logic [7:0]  cursor_line,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attribute,
	output int          fail_count,
	output int          pending
);

	localparam int SEQ_LEN = tep_pkg::ESC_BUF_LEN_DEF;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [15:0] cnt;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  chr;
		logic [7:0]  attr;
	} term_cmd_t;

	term_cmd_t expected_cmds[$];

	// Shadow copy of the parser state.
	logic [7:0] width_q, height_q;
	logic       in_seq;
	logic [7:0] seq_buf [SEQ_LEN];
	int         seq_len;
	logic [7:0] col_q, row_q;
	logic [7:0] base_fg, base_bg, live_fg, live_bg;

	function automatic logic [7:0] edge_col();
		return (width_q != 0) ? width_q - 8'd1 : 8'd0;
	endfunction

	function automatic logic [7:0] edge_row();
		return (height_q != 0) ? height_q - 8'd1 : 8'd0;
	endfunction

	function automatic logic [7:0] inc_sat(logic [7:0] v, logic [7:0] lim);
		return (v < lim) ? v + 8'd1 : lim;
	endfunction

	function automatic logic [7:0] dec_sat(logic [7:0] v);
		return (v != 0) ? v - 8'd1 : 8'd0;
	endfunction

	function automatic logic [7:0] code_page(logic [7:0] b);
		logic [7:0] hi [64];
		hi = '{8'hEE, 8'hA0, 8'hA1, 8'hE6, 8'hA4, 8'hA5, 8'hE4, 8'hA3,
			8'hE5, 8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
			8'hAF, 8'hEF, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hA6, 8'hA2,
			8'hEC, 8'hEB, 8'hA7, 8'hE8, 8'hED, 8'hE9, 8'hE7, 8'hEA,
			8'h9E, 8'h80, 8'h81, 8'h96, 8'h84, 8'h85, 8'h94, 8'h83,
			8'h95, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E,
			8'h8F, 8'h9F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h86, 8'h82,
			8'h9C, 8'h9B, 8'h87, 8'h98, 8'h9D, 8'h99, 8'h97, 8'h9A};
		if (b >= 8'hC0) return hi[b - 8'hC0];
		if (b >= 8'h80 && b < 8'h90) return b + 8'h50;
		if (b >= 8'hA0 && b < 8'hB0) return b + 8'h20;
		return b;
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Saturating decimal read starting at idx; missing or zero gives one.
	function automatic int parse_arg(inout int idx);
		int v;
		v = 0;
		while (idx < seq_len && idx < SEQ_LEN && is_num(seq_buf[idx])) begin
			v = v * 10 + (seq_buf[idx] - "0");
			if (v > 65535) v = 65535;
			idx++;
		end
		return (v != 0) ? v : 1;
	endfunction

	function automatic logic [7:0] arg_to_pos(int v, logic [7:0] lim);
		return (v - 1 > lim) ? lim : 8'(v - 1);
	endfunction

	task automatic push_cmd(logic [3:0] cmd, int cnt, logic [7:0] chr);
		term_cmd_t t;
		t.cmd = cmd;
		t.cnt = 16'(cnt);
		t.col = col_q;
		t.row = row_q;
		t.chr = chr;
		t.attr = live_bg | live_fg;
		expected_cmds.push_back(t);
	endtask

	// Advance the shadow state by one accepted byte.
	task automatic predict_byte(logic [7:0] b);
		int idx, a, c;
		if (b == tep_pkg::CODE_SI) return;
		if (b == tep_pkg::CODE_ESC) begin
			in_seq = 1;
			seq_len = 0;
			return;
		end
		if (!in_seq) begin
			if (b == tep_pkg::CODE_CR) col_q = 0;
			else if (b == tep_pkg::CODE_LF) row_q = inc_sat(row_q, edge_row());
			else col_q = inc_sat(col_q, edge_col());
			push_cmd(tep_pkg::CMD_CHAR, 1, code_page(b));
			return;
		end
		in_seq = 0;
		if (seq_len == 0) begin
			case (b)
				"A": begin row_q = dec_sat(row_q); push_cmd(tep_pkg::CMD_MOVE, 1, 0); end
				"B": begin
					row_q = inc_sat(row_q, edge_row());
					push_cmd(tep_pkg::CMD_MOVE, 1, 0);
				end
				"C": begin
					col_q = inc_sat(col_q, edge_col());
					push_cmd(tep_pkg::CMD_MOVE, 1, 0);
				end
				"D": begin col_q = dec_sat(col_q); push_cmd(tep_pkg::CMD_MOVE, 1, 0); end
				"H": begin col_q = 0; row_q = 0; push_cmd(tep_pkg::CMD_MOVE, 1, 0); end
				"K": push_cmd(tep_pkg::CMD_ERASE_EOL, 1, 0);
				"J": push_cmd(tep_pkg::CMD_ERASE_EOS, 1, 0);
				"Y", "[": begin
					seq_buf[0] = b;
					seq_len = 1;
					in_seq = 1;
				end
				default: ;
			endcase
			return;
		end
		if (seq_len >= SEQ_LEN - 1) return;
		seq_buf[seq_len] = b;
		seq_len++;
		if (seq_buf[0] == "Y") begin
			if (seq_len < 3) begin
				in_seq = 1;
				return;
			end
			row_q = (seq_buf[1] >= tep_pkg::CODE_SPACE) ?
				seq_buf[1] - tep_pkg::CODE_SPACE : 8'd0;
			if (row_q > edge_row()) row_q = edge_row();
			col_q = (seq_buf[2] >= tep_pkg::CODE_SPACE) ?
				seq_buf[2] - tep_pkg::CODE_SPACE : 8'd0;
			if (col_q > edge_col()) col_q = edge_col();
			push_cmd(tep_pkg::CMD_MOVE, 1, 0);
			return;
		end
		idx = 1;
		case (b)
			"A": begin row_q = dec_sat(row_q); push_cmd(tep_pkg::CMD_MOVE, 1, 0); end
			"B": begin
				row_q = inc_sat(row_q, edge_row());
				push_cmd(tep_pkg::CMD_MOVE, 1, 0);
			end
			"C": begin
				col_q = inc_sat(col_q, edge_col());
				push_cmd(tep_pkg::CMD_MOVE, 1, 0);
			end
			"D": begin col_q = dec_sat(col_q); push_cmd(tep_pkg::CMD_MOVE, 1, 0); end
			"K": push_cmd(tep_pkg::CMD_ERASE_EOL, 1, 0);
			"X": push_cmd(tep_pkg::CMD_ERASE_CH, parse_arg(idx), 0);
			"@": push_cmd(tep_pkg::CMD_INS_CH, parse_arg(idx), 0);
			"P": push_cmd(tep_pkg::CMD_DEL_CH, parse_arg(idx), 0);
			"L": push_cmd(tep_pkg::CMD_INS_LN, parse_arg(idx), 0);
			"M": push_cmd(tep_pkg::CMD_DEL_LN, parse_arg(idx), 0);
			"H": begin
				a = parse_arg(idx);
				c = 1;
				if (idx < seq_len && seq_buf[idx] == tep_pkg::CODE_SEMI) begin
					idx++;
					c = parse_arg(idx);
				end
				row_q = arg_to_pos(a, edge_row());
				col_q = arg_to_pos(c, edge_col());
				push_cmd(tep_pkg::CMD_MOVE, 1, 0);
			end
			"T": begin
				a = parse_arg(idx);
				col_q = 0;
				row_q = 0;
				push_cmd(tep_pkg::CMD_SCROLL_DN, a, 0);
			end
			"S": begin
				a = parse_arg(idx);
				col_q = 0;
				row_q = edge_row();
				push_cmd(tep_pkg::CMD_SCROLL_UP, a, 0);
			end
			"r": begin
				if (seq_buf[1] == tep_pkg::CODE_ZERO) begin
					live_fg = base_fg;
					live_bg = 0;
				end else begin
					live_fg = 0;
					live_bg = base_bg;
				end
				push_cmd(tep_pkg::CMD_SET_ATTR, 1, 0);
			end
			"u": begin
				if (seq_buf[1] == tep_pkg::CODE_ZERO) begin
					base_fg &= ~tep_pkg::FG_INTENS;
					base_bg &= ~tep_pkg::BG_INTENS;
				end else begin
					if (base_fg != 0) base_fg |= tep_pkg::FG_INTENS;
					if (base_bg != 0) base_bg |= tep_pkg::BG_INTENS;
				end
				if (live_fg != 0) live_fg = base_fg;
				if (live_bg != 0) live_bg = base_bg;
				push_cmd(tep_pkg::CMD_SET_ATTR, 1, 0);
			end
			default: in_seq = is_num(b) || b == tep_pkg::CODE_SEMI;
		endcase
	endtask

	task automatic compare_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Track configuration writes and both transfers at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		term_cmd_t e;
		if (!arst_n) begin
			width_q = tep_pkg::WIDTH_RST;
			height_q = tep_pkg::HEIGHT_RST;
			in_seq = 0;
			seq_len = 0;
			col_q = 0;
			row_q = 0;
			base_fg = tep_pkg::BASE_FORE_RST;
			base_bg = tep_pkg::BASE_BACK_RST;
			live_fg = tep_pkg::BASE_FORE_RST;
			live_bg = tep_pkg::BASE_BACK_RST;
			expected_cmds.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_index == tep_pkg::REG_WIDTH) width_q = cfg_data;
				else height_q = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					$error("command transfer with nothing expected");
					fail_count++;
				end else begin
					e = expected_cmds.pop_front();
					compare_field("command", e.cmd, command);
					compare_field("count", e.cnt, count);
					compare_field("cursor_column", e.col, cursor_column);
					compare_field("cursor_line", e.row, cursor_line);
					compare_field("char_code", e.chr, char_code);
					compare_field("attribute", e.attr, attribute);
				end
			end
			if (in_valid && in_ready) predict_byte(byte_in);
		end
		pending = expected_cmds.size();
	end

	initial begin
		fail_count = 0;
		pending = 0;
	end

endmodule

// ----- tb/testbench.sv -----
// Drives terminal byte streams into the escape parser under varying screen
// sizes and handshake pressure; the checker judges every command.
module testbench;

	logic        clk = 0, arst_n = 0;
	logic        cfg_write = 0, cfg_index = tep_pkg::REG_WIDTH;
	logic [7:0]  cfg_data = 0;
	logic        in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [7:0]  byte_in = 0;
	logic [3:0]  command;
	logic [15:0] count;
	logic [7:0]  cursor_column, cursor_line, char_code, attribute;
	int          fail_count, pending;
	int          send_idle_pct, recv_idle_pct;

	terminal_escape_parser_top dut (.*);
	escape_checker chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver stalls at random.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Valid stays high after a transfer only until the next falling edge,
	// where it either drops or carries the next byte.
	task automatic send_byte(logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		byte_in <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_str(string s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	task automatic send_esc(string s);
		send_byte(tep_pkg::CODE_ESC);
		send_str(s);
	endtask

	task automatic write_reg(logic idx, logic [7:0] v);
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 0;
	endtask

	// Wait for all commands, then for the longest argument walk.
	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (tep_pkg::ESC_BUF_LEN_DEF + 4) @(negedge clk);
	endtask

	function automatic string rand_digits();
		string s;
		int n;
		s = "";
		n = $urandom_range(6);
		repeat (n) s = {s, string'(8'("0" + $urandom_range(9)))};
		return s;
	endfunction

	// One random item: a random byte, a sequence (mostly well-formed) or some noise.
	task automatic send_random();
		string finals;
		int k;
		finals = "ABCDKXP@LMHTSru";
		k = $urandom_range(99);
		if (k < 40) send_byte(8'($urandom_range(255)));
		else if (k < 50) begin
			send_byte(tep_pkg::CODE_ESC);
			send_byte(8'("ABCDHKJZ" >> (8 * $urandom_range(7))));
		end else if (k < 58) begin
			send_byte(tep_pkg::CODE_ESC);
			send_byte("Y");
			send_byte(8'($urandom_range(255)));
			send_byte(8'($urandom_range(255)));
		end else if (k < 90) begin
			send_esc({"[", rand_digits()});
			if ($urandom_range(1)) send_str({";", rand_digits()});
			send_byte(finals[$urandom_range(finals.len() - 1)]);
		end else if (k < 95) begin
			send_esc({"[", rand_digits(), rand_digits(), rand_digits()});
			send_byte(8'($urandom_range(255)));
		end else send_byte($urandom_range(1) ? tep_pkg::CODE_SI : tep_pkg::CODE_ESC);
	endtask

	initial begin
		logic [7:0] sizes [6];
		sizes = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd80, 8'd13};
		send_idle_pct = 23;
		recv_idle_pct = 71;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: extremes, a selection of command forms, special cases.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(tep_pkg::CODE_CR);
		send_byte(tep_pkg::CODE_LF);
		send_byte(tep_pkg::CODE_SI);
		send_byte(tep_pkg::CODE_ESC);
		send_esc("B");
		send_esc("[0u");
		send_esc("[99999X");
		send_esc("[0;300H");
		send_esc("[0r");
		send_esc("[1r");
		send_esc("[1u");
		send_esc("[123456789012345678X");
		send_esc("[q");
		drain();
		write_reg(tep_pkg::REG_WIDTH, 8'd5);
		write_reg(tep_pkg::REG_HEIGHT, 8'd3);
		send_esc("Y");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_esc("[S");
		send_esc("[T");
		send_esc("J");
		drain();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 71;
				recv_idle_pct = 23;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(tep_pkg::REG_WIDTH, sizes[phase]);
			write_reg(tep_pkg::REG_HEIGHT, sizes[5 - phase]);
			repeat (48) send_random();
			drain();
		end
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule
